// ===== hdl/lrve_pkg.sv =====
// Shared types, constants and lookup tables of the line ring vector estimator.
package lrve_pkg;

   // ring geometry and number formats
   localparam int RING_SENSORS = 24;
   localparam int WORD_W       = RING_SENSORS + 3;
   localparam int FRAC_BITS    = 14;
   localparam int IDX_W        = 5;
   localparam int CNT_W        = 5;
   localparam int RUN_W        = 4;
   localparam int SUM_W        = 21;
   localparam int DIV_BITS     = 20;
   localparam int COR_W        = 34;

   // angle units: 2^32 per turn
   localparam logic signed [COR_W-1:0] TURN_HALF = 34'sd2147483648;
   localparam logic signed [COR_W-1:0] TURN_FULL = 34'sd4294967296;

   // configuration register indexes
   localparam logic REG_IGNORE_MASK = 1'b0;

   // side sensor codes
   localparam logic [2:0] SIDE_NONE  = 3'd0;
   localparam logic [2:0] SIDE_LEFT  = 3'd1;
   localparam logic [2:0] SIDE_RIGHT = 3'd2;
   localparam logic [2:0] SIDE_BOTH  = 3'd3;
   localparam logic [2:0] SIDE_REAR  = 3'd4;

   localparam logic signed [8:0] SIDE_ANG_LEFT  = 9'sd90;
   localparam logic signed [8:0] SIDE_ANG_RIGHT = -9'sd90;
   localparam logic signed [8:0] SIDE_ANG_BOTH  = 9'sd0;
   localparam logic signed [8:0] SIDE_ANG_REAR  = 9'sd180;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_SCAN, OP_FIX, OP_DIV_INIT, OP_DIV, OP_SAT,
      OP_COR_INIT, OP_COR, OP_CLAMP, OP_ROUND, OP_MUL, OP_COMMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic div_last;
      logic cor_last;
   } stat_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_FIX, ST_DIV_INIT, ST_DIV, ST_SAT, ST_COR_INIT,
      ST_COR, ST_CLAMP, ST_ROUND, ST_MUL, ST_DONE
   } state_type;

   // cosine of ring sensor idx (15 degree pitch), Q2.14
   function automatic logic signed [15:0] ring_cos(input logic [IDX_W-1:0] idx);
      logic signed [15:0] v;
      unique case (idx)
         5'd0:  v = 16'sd16384;
         5'd1:  v = 16'sd15826;
         5'd2:  v = 16'sd14189;
         5'd3:  v = 16'sd11585;
         5'd4:  v = 16'sd8192;
         5'd5:  v = 16'sd4240;
         5'd6:  v = 16'sd0;
         5'd7:  v = -16'sd4240;
         5'd8:  v = -16'sd8192;
         5'd9:  v = -16'sd11585;
         5'd10: v = -16'sd14189;
         5'd11: v = -16'sd15826;
         5'd12: v = -16'sd16384;
         5'd13: v = -16'sd15826;
         5'd14: v = -16'sd14189;
         5'd15: v = -16'sd11585;
         5'd16: v = -16'sd8192;
         5'd17: v = -16'sd4240;
         5'd18: v = 16'sd0;
         5'd19: v = 16'sd4240;
         5'd20: v = 16'sd8192;
         5'd21: v = 16'sd11585;
         5'd22: v = 16'sd14189;
         5'd23: v = 16'sd15826;
         default: v = 16'sd0;
      endcase
      return v;
   endfunction

   // sine is the cosine a quarter turn back
   function automatic logic signed [15:0] ring_sin(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] j;
      j = (idx >= 5'd6) ? 5'(idx - 5'd6) : 5'(idx + 5'd18);
      return ring_cos(j);
   endfunction

   // arctangent of 2^-k in 2^32 units per turn
   function automatic logic [29:0] atan_val(input logic [CNT_W-1:0] k);
      logic [29:0] v;
      unique case (k)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10679838;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         5'd20: v = 30'd652;
         5'd21: v = 30'd326;
         5'd22: v = 30'd163;
         5'd23: v = 30'd81;
         5'd24: v = 30'd41;
         5'd25: v = 30'd20;
         5'd26: v = 30'd10;
         5'd27: v = 30'd5;
         5'd28: v = 30'd3;
         5'd29: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/lrve_ctrl.sv =====
// Sequencing state machine of the line ring vector estimator.
module lrve_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  lrve_pkg::stat_type stat,
   output lrve_pkg::cmd_type  cmd
);

   lrve_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // state and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrve_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      cmd.op       = lrve_pkg::OP_NONE;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         lrve_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = lrve_pkg::OP_LOAD;
               state_in = lrve_pkg::ST_SCAN;
            end
         end
         lrve_pkg::ST_SCAN: begin
            cmd.op = lrve_pkg::OP_SCAN;
            if (stat.scan_last) state_in = lrve_pkg::ST_FIX;
         end
         lrve_pkg::ST_FIX: begin
            cmd.op   = lrve_pkg::OP_FIX;
            state_in = lrve_pkg::ST_DIV_INIT;
         end
         lrve_pkg::ST_DIV_INIT: begin
            cmd.op   = lrve_pkg::OP_DIV_INIT;
            state_in = lrve_pkg::ST_DIV;
         end
         lrve_pkg::ST_DIV: begin
            cmd.op = lrve_pkg::OP_DIV;
            if (stat.div_last) state_in = lrve_pkg::ST_SAT;
         end
         lrve_pkg::ST_SAT: begin
            cmd.op   = lrve_pkg::OP_SAT;
            state_in = lrve_pkg::ST_COR_INIT;
         end
         lrve_pkg::ST_COR_INIT: begin
            cmd.op   = lrve_pkg::OP_COR_INIT;
            state_in = lrve_pkg::ST_COR;
         end
         lrve_pkg::ST_COR: begin
            cmd.op = lrve_pkg::OP_COR;
            if (stat.cor_last) state_in = lrve_pkg::ST_CLAMP;
         end
         lrve_pkg::ST_CLAMP: begin
            cmd.op   = lrve_pkg::OP_CLAMP;
            state_in = lrve_pkg::ST_ROUND;
         end
         lrve_pkg::ST_ROUND: begin
            cmd.op   = lrve_pkg::OP_ROUND;
            state_in = lrve_pkg::ST_MUL;
         end
         lrve_pkg::ST_MUL: begin
            cmd.op   = lrve_pkg::OP_MUL;
            state_in = lrve_pkg::ST_DONE;
         end
         lrve_pkg::ST_DONE: begin
            // write the result word once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = lrve_pkg::OP_COMMIT;
               rsp_valid_in = 1'b1;
               state_in     = lrve_pkg::ST_IDLE;
            end
         end
         default: state_in = lrve_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/lrve_datapath.sv =====
// Datapath: ring scan, run-sum divider, vectoring CORDIC, escape and side logic.
module lrve_datapath #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lrve_pkg::cmd_type             cmd,
   output lrve_pkg::stat_type            stat,
   input  logic [lrve_pkg::RING_SENSORS-1:0] ignore_mask,
   input  logic [lrve_pkg::WORD_W-1:0]   req_sensor_word,
   output logic                          rsp_line_on,
   output logic [3:0]                    rsp_run_count,
   output logic signed [15:0]            rsp_line_x,
   output logic signed [15:0]            rsp_line_y,
   output logic signed [12:0]            rsp_line_angle,
   output logic                          rsp_line_appeared,
   output logic [3:0]                    rsp_first_sector,
   output logic signed [15:0]            rsp_go_x,
   output logic signed [15:0]            rsp_go_y,
   output logic [2:0]                    rsp_side_code,
   output logic signed [8:0]             rsp_side_angle
);

   localparam int RS = lrve_pkg::RING_SENSORS;
   localparam int CW = lrve_pkg::COR_W;
   localparam int SW = lrve_pkg::SUM_W;

   // negate with saturation
   function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
      return (v == -16'sd32768) ? 16'sd32767 : -v;
   endfunction

   // one restoring division step: {remainder, quotient shift register}
   function automatic logic [23:0] div_step(input logic [3:0] r, input logic [19:0] q,
                                           input logic [3:0] d);
      logic [4:0] r2;
      r2 = {r, q[19]};
      if (r2 >= {1'b0, d}) return {4'(r2 - {1'b0, d}), q[18:0], 1'b1};
      else return {r2[3:0], q[18:0], 1'b0};
   endfunction

   // negated mean from the quotient magnitude and the sign of the sum
   function automatic logic signed [15:0] mean_neg(input logic neg, input logic [19:0] q);
      logic signed [20:0] nq;
      nq = -$signed({1'b0, q});
      if (neg) return (q > 20'd32767) ? 16'sd32767 : 16'(q);
      else return (q > 20'd32768) ? -16'sd32768 : 16'(nq);
   endfunction

   // frame and scan state
   logic [lrve_pkg::WORD_W-1:0] word_ff, word_in;
   logic [lrve_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                        have_ff, have_in, inrun_ff, inrun_in;
   logic [lrve_pkg::IDX_W-1:0]  fu_ff, fu_in, lu_ff, lu_in, prev_ff, prev_in;
   logic [lrve_pkg::RUN_W-1:0]  nrun_ff, nrun_in;
   logic signed [lrve_pkg::SUM_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   // divider
   logic [lrve_pkg::DIV_BITS-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [3:0]                    rx_ff, rx_in, ry_ff, ry_in;
   // line vector and CORDIC
   logic signed [15:0]  lx_ff, lx_in, ly_ff, ly_in;
   logic signed [CW-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [32:0]          zc_ff, zc_in;
   logic signed [12:0]   angle_ff, angle_in;
   logic signed [31:0]   px_ff, px_in, py_ff, py_in;
   logic                 appeared_ff, appeared_in;
   // persistent state
   logic                 was_on_ff, was_on_in;
   logic signed [15:0]   first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic [3:0]           sector_ff, sector_in;
   logic signed [12:0]   held_angle_ff, held_angle_in;
   logic signed [8:0]    held_side_ff, held_side_in;
   logic signed [15:0]   go_x_ff, go_x_in, go_y_ff, go_y_in;
   // result word
   logic                 o_on_ff, o_on_in, o_app_ff, o_app_in;
   logic [3:0]           o_runs_ff, o_runs_in, o_sector_ff, o_sector_in;
   logic signed [15:0]   o_lx_ff, o_lx_in, o_ly_ff, o_ly_in;
   logic signed [15:0]   o_gx_ff, o_gx_in, o_gy_ff, o_gy_in;
   logic signed [12:0]   o_angle_ff, o_angle_in;
   logic [2:0]           o_side_ff, o_side_in;
   logic signed [8:0]    o_side_ang_ff, o_side_ang_in;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         was_on_ff     <= 1'b0;
         first_x_ff    <= '0;
         first_y_ff    <= '0;
         sector_ff     <= '0;
         held_angle_ff <= '0;
         held_side_ff  <= '0;
         go_x_ff       <= '0;
         go_y_ff       <= '0;
      end else begin
         cnt_ff        <= cnt_in;
         was_on_ff     <= was_on_in;
         first_x_ff    <= first_x_in;
         first_y_ff    <= first_y_in;
         sector_ff     <= sector_in;
         held_angle_ff <= held_angle_in;
         held_side_ff  <= held_side_in;
         go_x_ff       <= go_x_in;
         go_y_ff       <= go_y_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      have_ff       <= have_in;
      inrun_ff      <= inrun_in;
      fu_ff         <= fu_in;
      lu_ff         <= lu_in;
      prev_ff       <= prev_in;
      nrun_ff       <= nrun_in;
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      rx_ff         <= rx_in;
      ry_ff         <= ry_in;
      lx_ff         <= lx_in;
      ly_ff         <= ly_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      cz_ff         <= cz_in;
      zc_ff         <= zc_in;
      angle_ff      <= angle_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      appeared_ff   <= appeared_in;
      o_on_ff       <= o_on_in;
      o_app_ff      <= o_app_in;
      o_runs_ff     <= o_runs_in;
      o_sector_ff   <= o_sector_in;
      o_lx_ff       <= o_lx_in;
      o_ly_ff       <= o_ly_in;
      o_gx_ff       <= o_gx_in;
      o_gy_ff       <= o_gy_in;
      o_angle_ff    <= o_angle_in;
      o_side_ff     <= o_side_in;
      o_side_ang_ff <= o_side_ang_in;
   end

   // step counter end marks
   assign stat.scan_last = (cnt_ff == 5'(RS - 1));
   assign stat.div_last  = (cnt_ff == 5'(lrve_pkg::DIV_BITS - 1));
   assign stat.cor_last  = (cnt_ff == 5'(CORDIC_STEPS - 1));

   logic                       masked, lit, merge, on, app, sl, sr, sb;
   logic [lrve_pkg::IDX_W-1:0] vsel;
   logic signed [lrve_pkg::SUM_W-1:0] ax, ay;
   logic [23:0]                dx_step, dy_step;
   logic signed [CW-1:0]       x0, y0, shx, shy, at, zz;
   logic [45:0]                zprod;
   logic signed [13:0]         aext;
   logic [13:0]                av;
   logic [3:0]                 sec;
   logic signed [15:0]         fx, fy;
   logic signed [32:0]         dot;

   always_comb begin
      // hold by default
      word_in = word_ff;  cnt_in = cnt_ff;  have_in = have_ff;  inrun_in = inrun_ff;
      fu_in = fu_ff;  lu_in = lu_ff;  prev_in = prev_ff;  nrun_in = nrun_ff;
      sx_in = sx_ff;  sy_in = sy_ff;  qx_in = qx_ff;  qy_in = qy_ff;
      rx_in = rx_ff;  ry_in = ry_ff;  lx_in = lx_ff;  ly_in = ly_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  cz_in = cz_ff;  zc_in = zc_ff;
      angle_in = angle_ff;  px_in = px_ff;  py_in = py_ff;  appeared_in = appeared_ff;
      was_on_in = was_on_ff;  first_x_in = first_x_ff;  first_y_in = first_y_ff;
      sector_in = sector_ff;  held_angle_in = held_angle_ff;  held_side_in = held_side_ff;
      go_x_in = go_x_ff;  go_y_in = go_y_ff;
      o_on_in = o_on_ff;  o_app_in = o_app_ff;  o_runs_in = o_runs_ff;
      o_sector_in = o_sector_ff;  o_lx_in = o_lx_ff;  o_ly_in = o_ly_ff;
      o_gx_in = o_gx_ff;  o_gy_in = o_gy_ff;  o_angle_in = o_angle_ff;
      o_side_in = o_side_ff;  o_side_ang_in = o_side_ang_ff;

      masked  = ignore_mask[cnt_ff];
      lit     = word_ff[cnt_ff];
      vsel    = lit ? cnt_ff : prev_ff;
      merge   = (nrun_ff >= 4'd2) && word_ff[fu_ff] && word_ff[lu_ff];
      on      = (nrun_ff != 4'd0);
      app     = on && !was_on_ff;
      ax      = '0;
      ay      = '0;
      dx_step = div_step(rx_ff, qx_ff, nrun_ff);
      dy_step = div_step(ry_ff, qy_ff, nrun_ff);
      x0      = CW'(lx_ff) <<< lrve_pkg::FRAC_BITS;
      y0      = CW'(ly_ff) <<< lrve_pkg::FRAC_BITS;
      shx     = cy_ff >>> cnt_ff;
      shy     = cx_ff >>> cnt_ff;
      at      = CW'(lrve_pkg::atan_val(cnt_ff));
      zz      = cz_ff + lrve_pkg::TURN_HALF;
      zprod   = 46'(zc_ff) * 46'd5760 + 46'd2147483648;
      aext    = 14'(angle_ff);
      av      = (angle_ff < -13'sd240) ? 14'(aext + 14'sd6000) : 14'(aext + 14'sd240);
      sec     = '0;
      for (int k = 1; k < 12; k++) begin
         if (av >= 14'(480 * k)) sec = 4'(sec + 4'd1);
      end
      fx      = app ? lx_ff : first_x_ff;
      fy      = app ? ly_ff : first_y_ff;
      dot     = 33'(px_ff) + 33'(py_ff);
      sl      = word_ff[RS];
      sr      = word_ff[RS + 1];
      sb      = word_ff[RS + 2];

      unique case (cmd.op)
         lrve_pkg::OP_LOAD: begin
            word_in  = req_sensor_word;
            cnt_in   = '0;
            have_in  = 1'b0;
            inrun_in = 1'b0;
            fu_in    = '0;
            lu_in    = '0;
            prev_in  = '0;
            nrun_in  = '0;
            sx_in    = '0;
            sy_in    = '0;
         end
         // one sensor per cycle; a run edge adds the end sensor's unit vector
         lrve_pkg::OP_SCAN: begin
            cnt_in = 5'(cnt_ff + 5'd1);
            if (!masked) begin
               if (!have_ff) begin
                  fu_in   = cnt_ff;
                  have_in = 1'b1;
               end
               lu_in   = cnt_ff;
               prev_in = cnt_ff;
               if (lit != inrun_ff) begin
                  sx_in    = sx_ff + SW'(lrve_pkg::ring_cos(vsel));
                  sy_in    = sy_ff + SW'(lrve_pkg::ring_sin(vsel));
                  inrun_in = lit;
                  if (lit) nrun_in = 4'(nrun_ff + 4'd1);
               end
            end
         end
         // close the last run, or fold it into the first across the wrap
         lrve_pkg::OP_FIX: begin
            if (merge) begin
               sx_in   = sx_ff - SW'(lrve_pkg::ring_cos(fu_ff));
               sy_in   = sy_ff - SW'(lrve_pkg::ring_sin(fu_ff));
               nrun_in = 4'(nrun_ff - 4'd1);
            end else if (inrun_ff) begin
               sx_in = sx_ff + SW'(lrve_pkg::ring_cos(lu_ff));
               sy_in = sy_ff + SW'(lrve_pkg::ring_sin(lu_ff));
            end
         end
         // magnitude plus half the divisor, rounding away from zero
         lrve_pkg::OP_DIV_INIT: begin
            ax     = sx_ff[lrve_pkg::SUM_W-1] ? -sx_ff : sx_ff;
            ay     = sy_ff[lrve_pkg::SUM_W-1] ? -sy_ff : sy_ff;
            qx_in  = 20'(ax) + 20'(nrun_ff >> 1);
            qy_in  = 20'(ay) + 20'(nrun_ff >> 1);
            rx_in  = '0;
            ry_in  = '0;
            cnt_in = '0;
         end
         lrve_pkg::OP_DIV: begin
            rx_in  = dx_step[23:20];
            qx_in  = dx_step[19:0];
            ry_in  = dy_step[23:20];
            qy_in  = dy_step[19:0];
            cnt_in = 5'(cnt_ff + 5'd1);
         end
         lrve_pkg::OP_SAT: begin
            lx_in = on ? mean_neg(sx_ff[lrve_pkg::SUM_W-1], qx_ff) : 16'sd0;
            ly_in = on ? mean_neg(sy_ff[lrve_pkg::SUM_W-1], qy_ff) : 16'sd0;
         end
         // left half plane is rotated by half a turn first
         lrve_pkg::OP_COR_INIT: begin
            cnt_in = '0;
            if (lx_ff < 16'sd0) begin
               cx_in = -x0;
               cy_in = -y0;
               cz_in = (ly_ff >= 16'sd0) ? lrve_pkg::TURN_HALF : -lrve_pkg::TURN_HALF;
            end else begin
               cx_in = x0;
               cy_in = y0;
               cz_in = '0;
            end
         end
         lrve_pkg::OP_COR: begin
            cnt_in = 5'(cnt_ff + 5'd1);
            if (cy_ff >= 0) begin
               cx_in = cx_ff + shx;
               cy_in = cy_ff - shy;
               cz_in = cz_ff + at;
            end else begin
               cx_in = cx_ff - shx;
               cy_in = cy_ff + shy;
               cz_in = cz_ff - at;
            end
         end
         lrve_pkg::OP_CLAMP: begin
            if (zz < 0) zc_in = '0;
            else if (zz > lrve_pkg::TURN_FULL) zc_in = 33'(lrve_pkg::TURN_FULL);
            else zc_in = 33'(zz);
         end
         // turn to 1/16 degree, rounded
         lrve_pkg::OP_ROUND: begin
            angle_in = 13'($signed({1'b0, zprod[44:32]}) - 14'sd2880);
         end
         // latch on first appearance, form the dot product terms
         lrve_pkg::OP_MUL: begin
            appeared_in = app;
            if (on) held_angle_in = angle_ff;
            if (app) begin
               first_x_in = lx_ff;
               first_y_in = ly_ff;
               sector_in  = sec;
            end
            px_in = lx_ff * fx;
            py_in = ly_ff * fy;
         end
         lrve_pkg::OP_COMMIT: begin
            was_on_in = on;
            if (on) begin
               if (dot < 0) begin
                  go_x_in = lx_ff;
                  go_y_in = ly_ff;
               end else if (dot == 0) begin
                  go_x_in = neg_sat(first_x_ff);
                  go_y_in = neg_sat(first_y_ff);
               end else begin
                  go_x_in = neg_sat(lx_ff);
                  go_y_in = neg_sat(ly_ff);
               end
            end
            // side sensors
            o_side_in     = lrve_pkg::SIDE_NONE;
            o_side_ang_in = held_side_ff;
            if (sl && !sr) begin
               o_side_in     = lrve_pkg::SIDE_LEFT;
               o_side_ang_in = lrve_pkg::SIDE_ANG_LEFT;
            end else if (!sl && sr) begin
               o_side_in     = lrve_pkg::SIDE_RIGHT;
               o_side_ang_in = lrve_pkg::SIDE_ANG_RIGHT;
            end else if (sl && sr && !sb) begin
               o_side_in     = lrve_pkg::SIDE_BOTH;
               o_side_ang_in = lrve_pkg::SIDE_ANG_BOTH;
            end else if (sb) begin
               o_side_in     = lrve_pkg::SIDE_REAR;
               o_side_ang_in = lrve_pkg::SIDE_ANG_REAR;
            end
            held_side_in = o_side_ang_in;
            o_on_in      = on;
            o_app_in     = appeared_ff;
            o_runs_in    = nrun_ff;
            o_sector_in  = sector_ff;
            o_lx_in      = lx_ff;
            o_ly_in      = ly_ff;
            o_angle_in   = held_angle_ff;
            o_gx_in      = go_x_in;
            o_gy_in      = go_y_in;
         end
         default: begin
         end
      endcase
   end

   assign rsp_line_on       = o_on_ff;
   assign rsp_run_count     = o_runs_ff;
   assign rsp_line_x        = o_lx_ff;
   assign rsp_line_y        = o_ly_ff;
   assign rsp_line_angle    = o_angle_ff;
   assign rsp_line_appeared = o_app_ff;
   assign rsp_first_sector  = o_sector_ff;
   assign rsp_go_x          = o_gx_ff;
   assign rsp_go_y          = o_gy_ff;
   assign rsp_side_code     = o_side_ff;
   assign rsp_side_angle    = o_side_ang_ff;

endmodule

// ===== hdl/line_ring_vector_estimator_top.sv =====
// Top level of the line ring vector estimator: register port, controller, datapath.
//
//   channel | direction | handshake                 | word
//   req     | in        | req_valid / req_ready     | sensor_word (27 bits)
//   rsp     | out       | rsp_valid / rsp_ready     | line, escape and side fields
//   csr     | in/out    | psel, penable, pwrite     | ignore_mask at address 0
//
// From acceptance to its result word a frame takes one cycle per ring sensor for
// the scan, 20 divider steps and one CORDIC step per cycle, plus eight further
// steps (FIX, DIV_INIT, SAT, COR_INIT, CLAMP, ROUND, MUL, DONE). The controller
// returns to idle before the next frame is taken.
// A frame is accepted only while no other is being worked on; a finished word
// waits in the output register while the next frame is already accepted, and
// the last step stalls while that word is still unread.
// Reset is synchronous; the ignore mask returns to sensor 15 only.
module line_ring_vector_estimator_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [26:0]          req_sensor_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_line_on,
   output logic [3:0]           rsp_run_count,
   output logic signed [15:0]   rsp_line_x,
   output logic signed [15:0]   rsp_line_y,
   output logic signed [12:0]   rsp_line_angle,
   output logic                 rsp_line_appeared,
   output logic [3:0]           rsp_first_sector,
   output logic signed [15:0]   rsp_go_x,
   output logic signed [15:0]   rsp_go_y,
   output logic [2:0]           rsp_side_code,
   output logic signed [8:0]    rsp_side_angle,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   localparam int RS = lrve_pkg::RING_SENSORS;

   logic [RS-1:0]      mask_ff, mask_in;
   lrve_pkg::cmd_type  cmd;
   lrve_pkg::stat_type stat;
   logic               sel_mask;

   // ignore mask register
   assign sel_mask = (paddr[2] == lrve_pkg::REG_IGNORE_MASK);
   always_comb begin
      mask_in = mask_ff;
      if (psel && penable && pwrite && sel_mask) mask_in = pwdata[RS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= RS'(32768);
      end else begin
         mask_ff <= mask_in;
      end
   end

   assign prdata = sel_mask ? 32'(mask_ff) : 32'd0;
   assign pready = 1'b1;

   lrve_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lrve_datapath #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .ignore_mask       (mask_ff),
      .req_sensor_word   (req_sensor_word),
      .rsp_line_on       (rsp_line_on),
      .rsp_run_count     (rsp_run_count),
      .rsp_line_x        (rsp_line_x),
      .rsp_line_y        (rsp_line_y),
      .rsp_line_angle    (rsp_line_angle),
      .rsp_line_appeared (rsp_line_appeared),
      .rsp_first_sector  (rsp_first_sector),
      .rsp_go_x          (rsp_go_x),
      .rsp_go_y          (rsp_go_y),
      .rsp_side_code     (rsp_side_code),
      .rsp_side_angle    (rsp_side_angle)
   );

   // a line is on exactly when runs were found
   a_on_runs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_on == (rsp_run_count != 4'd0)))
      else $error("line_on disagrees with run_count");

   // no line: zero vector and no appearance
   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_line_on) |->
         (rsp_line_x == 16'sd0 && rsp_line_y == 16'sd0 && !rsp_line_appeared))
      else $error("line off but vector or appearance set");

   // on first appearance the escape direction is the negated line vector
   a_first_escape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_line_appeared && rsp_line_x != -16'sd32768) |->
         (rsp_go_x == 16'(-rsp_line_x)))
      else $error("escape direction wrong on appearance");

   // after a frame is taken the block is busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("frame accepted while busy");

endmodule
